// ===== rtl/lcgp_pkg.sv =====
// lcgp_pkg: shared constants and types for the LRU key-value cache.
// Depends on nothing; used by lcgp_rsp_if, the cell and the top level.
package lcgp_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int OCC_W      = $clog2(ENTRIES + 1);
    localparam int CAP_W      = 5;
    localparam int CAP_RESET  = 16;

    // access kinds
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    // one cache entry as it moves down the chain
    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_entry;

    // per-cell control from the top level
    typedef struct packed {
        logic step;    // an accepted access changes the chain this cycle
        logic insert;  // new key enters at the head, every cell shifts
        logic drop;    // this cell receives the evicted entry: clear its valid
    } t_cell_ctl;

endpackage

// ===== rtl/lcgp_ifs.sv =====
// lcgp_ifs: valid/ready channel interfaces for access words and result words.
// Depends on lcgp_pkg for the lcgp_rsp_if field widths.
interface lcgp_req_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [31:0]                     key;
    logic [31:0]                     value;

    modport source (output valid, output kind, output key, output value, input ready);
    modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface lcgp_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [lcgp_pkg::VALUE_BITS-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

// ===== rtl/lru_cache_get_put_core.sv =====
// lru_cache_get_put_core: fully associative LRU key-value cache, top level.
// Depends on lcgp_pkg, lcgp_ifs (lcgp_req_if, lcgp_rsp_if) and lcgp_cell.
//
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    kind, key, value
//  o_rsp     out  valid/ready    hit, read_value
//  capacity  in   i_cap_we       i_cap_wdata[4:0]
//
// One access word per cycle unless the output stalls; its result word appears in the cycle after acceptance.
// The rate is set by the row of cells: all positions compare in parallel and the
// recency chain shifts by one position in the same cycle.
// i_req.ready drops only while a result word waits and o_rsp.ready is low.
// Synchronous reset empties the cache and sets capacity to 16.
module lru_cache_get_put_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cap_we,
    input  logic [lcgp_pkg::CAP_W-1:0]      i_cap_wdata,
    lcgp_req_if.sink                        i_req,
    lcgp_rsp_if.source                      o_rsp
);

    localparam int N = lcgp_pkg::ENTRIES;

    logic [lcgp_pkg::CAP_W-1:0]      r_cap;
    logic [lcgp_pkg::OCC_W-1:0]      r_occ;
    logic [lcgp_pkg::OCC_W-1:0]      n_occ;
    logic                            r_out_valid;
    logic                            r_hit;
    logic [lcgp_pkg::VALUE_BITS-1:0] r_rd;

    lcgp_pkg::t_entry                w_entry [N];
    lcgp_pkg::t_cell_ctl             w_ctl   [N];
    logic [N-1:0]                    w_match;
    logic [N:0]                      w_chain;
    logic [N-1:0]                    w_valid_vec;
    lcgp_pkg::t_entry                w_head;
    logic [lcgp_pkg::KEY_BITS-1:0]   w_key;
    logic [lcgp_pkg::VALUE_BITS-1:0] w_hit_value;
    logic [lcgp_pkg::OCC_W-1:0]      w_cap_eff;
    logic                            w_accept;
    logic                            w_hit;
    logic                            w_put;
    logic                            w_full;
    logic                            w_insert;
    logic                            w_evict;

    // accept while the output register is free or being drained
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_key       = i_req.key[lcgp_pkg::KEY_BITS-1:0];
    assign w_put       = (i_req.kind == lcgp_pkg::KIND_PUT);

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lcgp_pkg::CAP_W'(lcgp_pkg::CAP_RESET);
        end else if (i_cap_we) begin
            r_cap <= i_cap_wdata;
        end
    end

    // clamp capacity to the number of cells
    assign w_cap_eff = (32'(r_cap) > N) ? lcgp_pkg::OCC_W'(N) : lcgp_pkg::OCC_W'(r_cap);

    // row of cells, chain of "hit at or below" running toward the head
    assign w_chain[N] = 1'b0;
    for (genvar g = 0; g < N; g++) begin : g_cell
        lcgp_pkg::t_entry w_prev;
        if (g == 0) begin : g_head
            assign w_prev = w_head;
        end else begin : g_body
            assign w_prev = w_entry[g-1];
        end
        lcgp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_prev  (w_prev),
            .i_key   (w_key),
            .i_chain (w_chain[g+1]),
            .o_entry (w_entry[g]),
            .o_match (w_match[g]),
            .o_chain (w_chain[g])
        );
        assign w_valid_vec[g] = w_entry[g].valid;
    end

    assign w_hit = w_chain[0];

    // select the stored value of the matching cell
    always_comb begin
        w_hit_value = '0;
        for (int i = 0; i < N; i++) begin
            if (w_match[i]) begin
                w_hit_value = w_hit_value | w_entry[i].value;
            end
        end
    end

    // miss handling: insert below capacity, evict-and-insert at or above it
    assign w_full   = (r_occ >= w_cap_eff);
    assign w_insert = w_put && !w_hit && (!w_full || (r_occ != '0));
    assign w_evict  = w_put && !w_hit && w_full && (r_occ != '0);

    // head word: promoted entry on a hit, new entry on insert
    assign w_head = '{valid: 1'b1, key: w_key,
                      value: w_put ? i_req.value[lcgp_pkg::VALUE_BITS-1:0] : w_hit_value};

    // per-cell control; the cell just past the last valid one drops the victim
    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_ctl[i].step   = w_accept;
            w_ctl[i].insert = w_insert;
            w_ctl[i].drop   = w_evict
                              && (lcgp_pkg::OCC_W'(i) == r_occ);
        end
    end

    // occupancy grows only on an insert without eviction
    always_comb begin
        n_occ = r_occ;
        if (w_accept && w_insert && !w_evict) begin
            n_occ = r_occ + lcgp_pkg::OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    // output register: load on accept, drop on drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit <= w_hit;
            r_rd  <= (w_hit && !w_put) ? w_hit_value : '0;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_hit;
    assign o_rsp.read_value = r_rd;

    // valid cells always form a contiguous run from the head of length occupancy
    logic [N-1:0] w_occ_mask;
    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_occ_mask[i] = (lcgp_pkg::OCC_W'(i) < r_occ);
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_occ) <= N)
        else $error("occupancy above cell count");

    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid_vec == w_occ_mask)
        else $error("valid cells do not match occupancy");

    a_unique_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("key present in more than one cell");

    a_put_at_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_put && (w_hit || w_insert)) |=>
            (w_entry[0].valid && (w_entry[0].key == $past(w_key))))
        else $error("stored key not at head after put");

endmodule

// ===== rtl/lcgp_cell.sv =====
// lcgp_cell: one recency position of the LRU chain (position 0 = most recent).
// Depends on lcgp_pkg; instantiated in a row by lru_cache_get_put_core.
module lcgp_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lcgp_pkg::t_cell_ctl           i_ctl,
    input  lcgp_pkg::t_entry              i_prev,
    input  logic [lcgp_pkg::KEY_BITS-1:0] i_key,
    input  logic                          i_chain,
    output lcgp_pkg::t_entry              o_entry,
    output logic                          o_match,
    output logic                          o_chain
);

    logic                            r_valid;
    logic [lcgp_pkg::KEY_BITS-1:0]   r_key;
    logic [lcgp_pkg::VALUE_BITS-1:0] r_value;
    logic                            w_shift;

    // compare the lookup key; pass "hit here or further down" toward the head
    assign o_match = r_valid && (r_key == i_key);
    assign o_chain = o_match | i_chain;

    // shift from the neighbor on insert, or when the hit lies at or below this cell
    assign w_shift = i_ctl.step && (i_ctl.insert || o_chain);

    // clear valid under reset, advance it with the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_shift) begin
            r_valid <= i_prev.valid && !i_ctl.drop;
        end
    end

    // advance key and value with the chain
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_key   <= i_prev.key;
            r_value <= i_prev.value;
        end
    end

    assign o_entry = '{valid: r_valid, key: r_key, value: r_value};

endmodule
